FILE: hdl/ott_pkg.sv
// Shared types, constants and codes of the one-shot timer table.
package ott_pkg;

  localparam int SLOTS   = 32;
  // slot_out is 5 bits wide, so at most 32 entries are in use
  localparam int TABLE_N = (SLOTS > 32) ? 32 : SLOTS;
  localparam int IDX_W   = (TABLE_N > 1) ? $clog2(TABLE_N) : 1;
  localparam int RAM_D   = 1 << IDX_W;
  localparam int CNT_W   = 6;
  localparam int NOW_W   = 32;
  localparam int TAG_W   = 8;
  localparam int SEL_W   = 7;
  localparam int SLOT_W  = 5;
  localparam int ENT_W   = NOW_W + TAG_W;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_CREATE  = 2'd1;
  localparam logic [1:0] ACT_DELETE  = 2'd2;
  localparam logic [1:0] ACT_SERVICE = 2'd3;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRED = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic tick;
    logic del;
    logic now_clr;
    logic idx_clr;
    logic idx_inc;
    logic cr_load;
    logic cr_write;
    logic fire;
    logic out_reply;
    logic out_pend;
    logic rep_ok;
    logic last;
  } ott_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tag_zero;
    logic full;
    logic used_zero;
    logic cur_valid;
    logic due;
    logic idx_last;
    logic pend_valid;
    logic out_free;
  } ott_stat_t;

endpackage

FILE: hdl/ott_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ott_dp.sv
// Datapath: time counter, valid bits, entry RAM, pending result and output register.
module ott_dp import ott_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ott_cmd_t          cmd_i,
  input  logic [NOW_W-1:0]  offset_i,
  input  logic [SEL_W-1:0]  slot_sel_i,
  input  logic [TAG_W-1:0]  task_tag_i,
  input  logic              m_tready_i,
  output ott_stat_t         stat_o,
  output logic              m_tvalid_o,
  output logic              m_kind_o,
  output logic              m_ok_o,
  output logic [SLOT_W-1:0] m_slot_o,
  output logic [TAG_W-1:0]  m_tag_o,
  output logic              m_last_o
);

  localparam logic [SEL_W-1:0] SEL_LIMIT = SEL_W'(TABLE_N);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_N - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(TABLE_N);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  logic [NOW_W-1:0]   now_q;
  logic [CNT_W-1:0]   used_q;
  logic [TABLE_N-1:0] valid_q;
  logic [IDX_W-1:0]   idx_q;
  logic [NOW_W-1:0]   off_q;
  logic [TAG_W-1:0]   tag_q;
  logic               pend_valid_q;
  logic [IDX_W-1:0]   pend_slot_q;
  logic [TAG_W-1:0]   pend_tag_q;
  logic               out_valid_q;
  logic               out_kind_q;
  logic               out_ok_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic               out_last_q;

  logic [IDX_W-1:0]   rd_addr;
  logic [ENT_W-1:0]   wr_data;
  logic [ENT_W-1:0]   rd_data;
  logic [NOW_W-1:0]   rd_deadline;
  logic [TAG_W-1:0]   rd_tag;
  logic [IDX_W-1:0]   sel_idx;
  logic               del_hit;
  logic               out_free;

  // read one ahead while the scan advances, so the entry of the next slot is ready as the index moves on
  assign rd_addr     = cmd_i.idx_inc ? IDX_W'(idx_q + 1'b1) : idx_q;
  assign wr_data     = {tag_q, now_q + off_q};
  assign rd_deadline = rd_data[NOW_W-1:0];
  assign rd_tag      = rd_data[ENT_W-1:NOW_W];

  ott_ram #(
    .WIDTH(ENT_W),
    .DEPTH(RAM_D)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.cr_write),
    .waddr_i(idx_q),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign sel_idx  = slot_sel_i[IDX_W-1:0];
  assign del_hit  = (slot_sel_i < SEL_LIMIT) && valid_q[sel_idx];
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    stat_o.tag_zero   = (task_tag_i == '0);
    stat_o.full       = (used_q >= CNT_FULL);
    stat_o.used_zero  = (used_q == '0);
    stat_o.cur_valid  = valid_q[idx_q];
    stat_o.due        = valid_q[idx_q] && (now_q >= rd_deadline);
    stat_o.idx_last   = (idx_q == IDX_LAST);
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = out_free;
  end

  // table bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      used_q  <= '0;
      valid_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= IDX_W'(idx_q + 1'b1);
      end

      if (cmd_i.tick) begin
        now_q <= now_q + 1'b1;
      end else if (cmd_i.now_clr) begin
        now_q <= '0;
      end

      if (cmd_i.del && del_hit) begin
        valid_q[sel_idx] <= 1'b0;
        used_q           <= used_q - 1'b1;
        if (used_q == CNT_ONE) begin
          now_q <= '0;
        end
      end else if (cmd_i.fire) begin
        valid_q[idx_q] <= 1'b0;
        used_q         <= used_q - 1'b1;
        if (used_q == CNT_ONE) begin
          now_q <= '0;
        end
      end else if (cmd_i.cr_write) begin
        valid_q[idx_q] <= 1'b1;
        used_q         <= used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cr_load) begin
      off_q <= offset_i;
      tag_q <= task_tag_i;
    end
  end

  // pending fired entry: held until the next due entry or the scan end sets last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.fire) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.out_pend && cmd_i.last) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      pend_slot_q <= idx_q;
      pend_tag_q  <= rd_tag;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_reply || cmd_i.out_pend) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_reply) begin
      out_kind_q <= KIND_REPLY;
      out_ok_q   <= cmd_i.rep_ok;
      out_slot_q <= cmd_i.rep_ok ? SLOT_W'(idx_q) : '0;
      out_tag_q  <= '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.out_pend) begin
      out_kind_q <= KIND_FIRED;
      out_ok_q   <= 1'b0;
      out_slot_q <= SLOT_W'(pend_slot_q);
      out_tag_q  <= pend_tag_q;
      out_last_q <= cmd_i.last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_kind_o   = out_kind_q;
  assign m_ok_o     = out_ok_q;
  assign m_slot_o   = out_slot_q;
  assign m_tag_o    = out_tag_q;
  assign m_last_o   = out_last_q;

  a_used_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) == $countones(valid_q))
    else $error("used count out of step with valid bits");

  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_FULL)
    else $error("used count beyond table size");

  a_fire_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire |-> valid_q[idx_q])
    else $error("fired an empty slot");

  a_write_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cr_write |-> !valid_q[idx_q] && !stat_o.full)
    else $error("create wrote an occupied slot");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_reply || cmd_i.out_pend) |-> out_free)
    else $error("output register overwritten");

endmodule

FILE: hdl/ott_ctrl.sv
// Controller: sequences tick, create, delete and service scan over the datapath.
module ott_ctrl import ott_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic [1:0] action_i,
  input  ott_stat_t  stat_i,
  output logic       s_tready_o,
  output ott_cmd_t   cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CSCAN = 3'd1;
  localparam logic [2:0] ST_REPLY = 3'd2;
  localparam logic [2:0] ST_SRD   = 3'd3;
  localparam logic [2:0] ST_SCHK  = 3'd4;
  localparam logic [2:0] ST_SEND  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       rep_ok_q, rep_ok_d;
  logic       accept;
  logic       can_fire;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign can_fire   = !stat_i.pend_valid || stat_i.out_free;

  always_comb begin
    state_d  = state_q;
    rep_ok_d = rep_ok_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_TICK:   cmd_o.tick = 1'b1;
            ACT_DELETE: cmd_o.del  = 1'b1;
            ACT_CREATE: begin
              cmd_o.cr_load = 1'b1;
              cmd_o.idx_clr = 1'b1;
              if (stat_i.tag_zero || stat_i.full) begin
                rep_ok_d = 1'b0;
                state_d  = ST_REPLY;
              end else begin
                state_d = ST_CSCAN;
              end
            end
            ACT_SERVICE: begin
              if (stat_i.used_zero) begin
                cmd_o.now_clr = 1'b1;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = ST_SRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CSCAN: begin
        // a free slot exists, the table was not full
        if (!stat_i.cur_valid) begin
          cmd_o.cr_write = 1'b1;
          rep_ok_d       = 1'b1;
          state_d        = ST_REPLY;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_REPLY: begin
        if (stat_i.out_free) begin
          cmd_o.out_reply = 1'b1;
          cmd_o.rep_ok    = rep_ok_q;
          state_d         = ST_IDLE;
        end
      end
      ST_SRD: state_d = ST_SCHK;
      ST_SCHK: begin
        if (!stat_i.due || can_fire) begin
          if (stat_i.due) begin
            cmd_o.fire     = 1'b1;
            cmd_o.out_pend = stat_i.pend_valid;
          end
          if (stat_i.idx_last) begin
            state_d = ST_SEND;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_SEND: begin
        if (!stat_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.out_pend = 1'b1;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rep_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rep_ok_q <= rep_ok_d;
    end
  end

  a_cmd_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.tick, cmd_o.del, cmd_o.cr_write, cmd_o.fire, cmd_o.out_reply}))
    else $error("conflicting datapath commands");

  a_scan_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND && !stat_i.pend_valid) |=> state_q == ST_IDLE)
    else $error("scan end did not return to idle");

  a_srd_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRD |=> state_q == ST_SCHK)
    else $error("first scan read not followed by check");

endmodule

FILE: hdl/oneshot_timer_table.sv
// Top level of the one-shot timer table: stream ports, controller and datapath.
// Tick and delete complete in the accept cycle; the next item can be taken in the following cycle.
// Create walks the valid bits for the lowest free slot (unless refused), then sends its reply.
// Service: one slot per cycle off the RAM, held while a fired entry waits on the output.
// Reset (rst_ni low, async) clears the time counter, valid bits, counts and output stage;
// the entry RAM is not cleared, only valid entries are ever used.
module oneshot_timer_table import ott_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // offset[31:0], slot_sel[38:32], task_tag[46:39], pad
  input  logic [1:0]  s_axis_tuser_i,   // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // ok[0], slot_out[5:1], tag_out[13:6], pad
  output logic        m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // last
);

  ott_cmd_t          cmd;
  ott_stat_t         stat;
  logic              out_ok;
  logic [SLOT_W-1:0] out_slot;
  logic [TAG_W-1:0]  out_tag;

  // controller only moves on a transfer in idle; no work overlaps
  ott_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .action_i  (s_axis_tuser_i),
    .stat_i    (stat),
    .s_tready_o(s_axis_tready_o),
    .cmd_o     (cmd)
  );

  // input fields are used in the accept cycle; create latches offset and tag
  ott_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .offset_i  (s_axis_tdata_i[31:0]),
    .slot_sel_i(s_axis_tdata_i[38:32]),
    .task_tag_i(s_axis_tdata_i[46:39]),
    .m_tready_i(m_axis_tready_i),
    .stat_o    (stat),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_kind_o  (m_axis_tuser_o),
    .m_ok_o    (out_ok),
    .m_slot_o  (out_slot),
    .m_tag_o   (out_tag),
    .m_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_tag, out_slot, out_ok};

endmodule

FILE: sim/tb_oneshot_timer_table.sv
// Self-checking testbench for the one-shot timer table: directed and random actions.
`timescale 1ns / 100ps

module tb_oneshot_timer_table;
  import ott_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  // longest walk of one item plus output slack
  localparam int DRAIN_CYCLES = TABLE_N + 8;

  // one result transfer, unpacked
  typedef struct packed {
    logic       kind;
    logic       ok;
    logic [4:0] slot;
    logic [7:0] tag;
    logic       last;
  } timer_result_t;

  // Timer table predictor plus the queue of results it expects.
  class timer_scoreboard;
    logic [31:0]   now_ticks;
    logic [31:0]   due_at[TABLE_N];
    logic [7:0]    owner[TABLE_N];
    bit            live[TABLE_N];
    int unsigned   live_count;
    timer_result_t awaited_q[$];
    int unsigned   mismatches;
    int unsigned   replies_checked;
    int unsigned   fired_checked;

    function new();
      now_ticks       = '0;
      live_count      = 0;
      mismatches      = 0;
      replies_checked = 0;
      fired_checked   = 0;
      foreach (live[i]) begin
        live[i]   = 1'b0;
        due_at[i] = '0;
        owner[i]  = '0;
      end
    endfunction

    // frees one slot; the clock restarts once the table drains
    function void release_slot(int unsigned s);
      if (s >= TABLE_N || !live[s]) return;
      live[s] = 1'b0;
      live_count--;
      if (live_count == 0) now_ticks = '0;
    endfunction

    function void note_item(logic [1:0] act, logic [31:0] off, logic [6:0] sel,
                            logic [7:0] tag);
      timer_result_t r;
      int            found;
      int            first_new;
      found     = -1;
      first_new = awaited_q.size();
      r         = '0;
      case (act)
        ACT_TICK: begin
          now_ticks = now_ticks + 32'd1;
        end
        ACT_CREATE: begin
          if (tag != 8'd0 && live_count < TABLE_N) begin
            for (int i = 0; i < TABLE_N; i++) begin
              if (found < 0 && !live[i]) found = i;
            end
          end
          r.kind = KIND_REPLY;
          r.last = 1'b1;
          if (found >= 0) begin
            due_at[found] = now_ticks + off;
            owner[found]  = tag;
            live[found]   = 1'b1;
            live_count++;
            r.ok   = 1'b1;
            r.slot = found[4:0];
          end
          awaited_q.push_back(r);
        end
        ACT_DELETE: begin
          release_slot(sel);
        end
        default: begin
          if (live_count == 0) begin
            now_ticks = '0;
          end else begin
            for (int i = 0; i < TABLE_N; i++) begin
              if (live[i] && now_ticks >= due_at[i]) begin
                r      = '0;
                r.kind = KIND_FIRED;
                r.slot = i[4:0];
                r.tag  = owner[i];
                release_slot(i);
                awaited_q.push_back(r);
              end
            end
            // tlast goes on the final fired timer of this scan
            if (awaited_q.size() > first_new) awaited_q[awaited_q.size() - 1].last = 1'b1;
          end
        end
      endcase
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: kind=%0d ok=%0d slot=%0d tag=%02h last=%0d",
                   $realtime, got.kind, got.ok, got.slot, got.tag, got.last);
        return;
      end
      want = awaited_q.pop_front();
      if (want.kind == KIND_FIRED) fired_checked++;
      else replies_checked++;
      if (got.kind !== want.kind || got.ok !== want.ok || got.slot !== want.slot ||
          got.tag !== want.tag || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] mismatch: kind %0d/%0d ok %0d/%0d slot %0d/%0d ",
                    "tag %02h/%02h last %0d/%0d (expected/actual)"}, $realtime,
                   want.kind, got.kind, want.ok, got.ok, want.slot, got.slot,
                   want.tag, got.tag, want.last, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata = '0;   // offset[31:0], slot_sel[38:32], task_tag[46:39], pad
  logic [1:0]  s_axis_tuser = ACT_TICK;   // action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata_o;   // ok[0], slot_out[5:1], tag_out[13:6], pad
  logic        m_axis_tuser_o;   // kind
  logic        m_axis_tlast_o;   // last

  timer_scoreboard sb = new();
  int          src_idle_pct = 0;
  int          dst_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  oneshot_timer_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check each transfer, then pick next cycle's tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready)
      sb.check_result({m_axis_tuser_o, m_axis_tdata_o[0], m_axis_tdata_o[5:1],
                       m_axis_tdata_o[13:6], m_axis_tlast_o});
    m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one input transfer; ready is sampled as it stood at the edge
  task automatic send_item(input logic [1:0] act, input logic [31:0] off,
                           input logic [6:0] sel, input logic [7:0] tag);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, tag, sel, off};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(act, off, sel, tag);
    items_sent++;
  endtask

  task automatic run_phase(input int n_items, input int src_pct, input int dst_pct,
                           input bit with_fill);
    int unsigned start;
    int          pick;
    logic [1:0]  act;
    logic [31:0] off;
    logic [6:0]  sel;
    logic [7:0]  tag;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    if (with_fill) begin
      // fill the table past full with near-due timers, then expire them in one scan
      repeat (TABLE_N - sb.live_count + 2)
        send_item(ACT_CREATE, $urandom_range(0, 3), 7'($urandom),
                  8'($urandom_range(1, 255)));
      repeat (4) send_item(ACT_TICK, $urandom, 7'($urandom), 8'($urandom));
      send_item(ACT_SERVICE, $urandom, 7'($urandom), 8'($urandom));
    end
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        // schedule a few timers, let time pass, then service
        repeat ($urandom_range(2, 6))
          send_item(ACT_CREATE, $urandom_range(0, 12), 7'($urandom),
                    8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 10))
          send_item(ACT_TICK, $urandom, 7'($urandom), 8'($urandom));
        send_item(ACT_SERVICE, $urandom, 7'($urandom), 8'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        off  = $urandom;
        sel  = 7'($urandom);
        tag  = 8'($urandom);
        if (pick < 30) begin
          act = ACT_TICK;
        end else if (pick < 65) begin
          act = ACT_CREATE;
          case ($urandom_range(0, 9))
            0:       tag = 8'h00;
            1:       off = 32'hFFFF_FFFF - $urandom_range(0, 8);   // wraps past zero
            2, 3:    ;
            default: off = $urandom_range(0, 12);
          endcase
        end else if (pick < 80) begin
          act = ACT_DELETE;
          if ($urandom_range(0, 4) != 0) sel = 7'($urandom_range(0, TABLE_N - 1));
        end else begin
          act = ACT_SERVICE;
        end
        send_item(act, off, sel, tag);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner cases of the table and the clock
    send_item(ACT_SERVICE, 32'h0, 7'h0, 8'h00);           // scan of an empty table
    send_item(ACT_CREATE, 32'd5, 7'h0, 8'h00);            // zero tag is refused
    send_item(ACT_CREATE, 32'h0, 7'h0, 8'hFF);            // slot 0, due now
    send_item(ACT_CREATE, 32'hFFFF_FFFF, 7'h7F, 8'h01);   // slot 1, far off
    send_item(ACT_TICK, 32'h0, 7'h0, 8'h00);
    send_item(ACT_CREATE, 32'hFFFF_FFFF, 7'h0, 8'hA5);    // deadline wraps to 0, due at once
    send_item(ACT_DELETE, 32'h0, 7'h7F, 8'h00);           // slot beyond the table
    send_item(ACT_DELETE, 32'h0, 7'd32, 8'h00);           // first slot past the end
    send_item(ACT_DELETE, 32'h0, 7'd5, 8'h00);            // slot never used
    send_item(ACT_SERVICE, 32'h0, 7'h0, 8'h00);           // fires slots 0 and 2
    send_item(ACT_DELETE, 32'h0, 7'd1, 8'h00);            // last entry gone, clock clears
    send_item(ACT_TICK, 32'h0, 7'h0, 8'h00);
    send_item(ACT_TICK, 32'h0, 7'h0, 8'h00);
    send_item(ACT_CREATE, 32'd3, 7'h0, 8'h5A);
    send_item(ACT_SERVICE, 32'h0, 7'h0, 8'h00);           // nothing due yet
    repeat (3) send_item(ACT_TICK, 32'h0, 7'h0, 8'h00);
    send_item(ACT_SERVICE, 32'h0, 7'h0, 8'h00);           // fires the last entry
    send_item(ACT_CREATE, 32'h8000_0000, 7'h0, 8'h02);
    send_item(ACT_CREATE, 32'h7FFF_FFFF, 7'h0, 8'h40);
    send_item(ACT_DELETE, 32'h0, 7'd0, 8'h00);
    send_item(ACT_DELETE, 32'h0, 7'd1, 8'h00);

    // random: sender busy, receiver stalling; then swapped, with a table fill; then full rate
    run_phase(55, 10, 78, 1'b0);
    run_phase(55, 78, 10, 1'b1);
    run_phase(55, 0, 0, 1'b0);
    s_axis_tvalid <= 1'b0;

    while (sb.awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d actions, %0d create replies and %0d fired timers checked",
             items_sent, sb.replies_checked, sb.fired_checked);
    $display("%0d mismatches, %0d cycles", sb.mismatches, cycle_count);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: oneshot_timer_table.f
hdl/ott_pkg.sv
hdl/ott_ram.sv
hdl/ott_dp.sv
hdl/ott_ctrl.sv
hdl/oneshot_timer_table.sv
sim/tb_oneshot_timer_table.sv
